### rtl/lrgf_pkg.sv
// shared types and constants for the lidar ray ground filter
package lrgf_pkg;

    // configuration register indexes and port widths
    localparam logic [1:0] CFG_SLOPE  = 2'd0;
    localparam logic [1:0] CFG_DROP   = 2'd1;
    localparam logic [1:0] CFG_RISE   = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // slope tangent is q4.8, kept internally as its square
    localparam int SLOPE_BITS    = 12;
    localparam int SLOPE_SQ_BITS = 24;
    localparam int SLOPE_SHIFT   = 16;
    localparam int LIMIT_BITS    = 16;

    // reset values
    localparam logic [SLOPE_SQ_BITS-1:0] SLOPE_SQ_RESET = 24'd65536;
    localparam logic [LIMIT_BITS-1:0]    DROP_RESET     = 16'd100;
    localparam logic [LIMIT_BITS-1:0]    RISE_RESET     = 16'd100;
    localparam logic [LIMIT_BITS-1:0]    HEIGHT_RESET   = 16'd1800;

    // width of one slice of the squared planar distance for the slope multiply
    localparam int PART_BITS = 32;

    // queue between classifier and mode tracker
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [SLOPE_SQ_BITS-1:0] slope_sq;
        logic [LIMIT_BITS-1:0]    drop_limit;
        logic [LIMIT_BITS-1:0]    rise_limit;
        logic [LIMIT_BITS-1:0]    sensor_height;
    } lrgf_cfg_t;

endpackage

### rtl/lidar_ray_ground_filter.sv
// top level of the lidar ray ground filter: config registers, stream ports, front and back
// Points stream in ray by ray, one transfer per cycle sustained; each point judges the
// point held before it, and a held point found to stand too high above the last break
// in its ray leaves as a result (ground points and the last point of a ray never leave).
// A result reaches the output register after the point that follows it is taken, through
// seven register stages of break tests (input capture, differences, squares, sums,
// sliced slope multiply, its sum, compare), the four-entry queue, then the mode
// tracker. The input stalls only when the queue is full and the last test stage
// holds a verdict.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while no points are in flight.
module lidar_ray_ground_filter #(
    parameter int COORD_BITS = 24
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [lrgf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [lrgf_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_tdata,   // px, py, pz
    input  logic                                   s_tuser,   // ray_start
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_tdata    // ox, oy, oz
);

    localparam int CB  = COORD_BITS;
    localparam int DW  = ((3*CB+7)/8)*8;
    localparam int EW  = 3*CB + 2;
    localparam int SB  = lrgf_pkg::SLOPE_BITS;
    localparam int SQB = lrgf_pkg::SLOPE_SQ_BITS;
    localparam int LB  = lrgf_pkg::LIMIT_BITS;

    logic [SQB-1:0] slope_ext;
    logic [SQB-1:0] slope_sq_reg;
    logic [LB-1:0]  drop_limit_reg, rise_limit_reg, sensor_height_reg;
    lrgf_pkg::lrgf_cfg_t cfg;

    logic          q_push, q_full, q_pop, q_valid;
    logic [EW-1:0] q_wdata, q_rdata;
    logic [CB-1:0] o_x, o_y, o_z;

    // configuration writes; slope tangent is squared on the way in
    assign slope_ext = SQB'(cfg_wdata[SB-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slope_sq_reg      <= lrgf_pkg::SLOPE_SQ_RESET;
            drop_limit_reg    <= lrgf_pkg::DROP_RESET;
            rise_limit_reg    <= lrgf_pkg::RISE_RESET;
            sensor_height_reg <= lrgf_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                lrgf_pkg::CFG_SLOPE:  slope_sq_reg      <= slope_ext * slope_ext;
                lrgf_pkg::CFG_DROP:   drop_limit_reg    <= cfg_wdata[LB-1:0];
                lrgf_pkg::CFG_RISE:   rise_limit_reg    <= cfg_wdata[LB-1:0];
                lrgf_pkg::CFG_HEIGHT: sensor_height_reg <= cfg_wdata[LB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.slope_sq      = slope_sq_reg;
        cfg.drop_limit    = drop_limit_reg;
        cfg.rise_limit    = rise_limit_reg;
        cfg.sensor_height = sensor_height_reg;
    end

    // break tests
    lrgf_front #(
        .CB(CB)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_x     (s_tdata[CB-1:0]),
        .in_y     (s_tdata[2*CB-1:CB]),
        .in_z     (s_tdata[3*CB-1:2*CB]),
        .in_start (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_wdata)
    );

    // decoupling queue
    lrgf_queue #(
        .W(EW)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rdata   (q_rdata)
    );

    // mode tracking and result register
    lrgf_back #(
        .CB(CB)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_entry (q_rdata),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_x     (o_x),
        .m_y     (o_y),
        .m_z     (o_z)
    );

    assign m_tdata = DW'({o_z, o_y, o_x});

endmodule

### rtl/lrgf_front.sv
// front part: takes points, pairs each with the held point and runs the break tests
module lrgf_front #(
    parameter int CB = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lrgf_pkg::lrgf_cfg_t cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CB-1:0]       in_x,
    input  logic [CB-1:0]       in_y,
    input  logic [CB-1:0]       in_z,
    input  logic                in_start,
    input  logic                q_full,
    output logic                q_push,
    output logic [3*CB+1:0]     q_entry   // x, y, z, start, break from lowest bit up
);

    localparam int MW   = CB + 2;
    localparam int SQW  = 2 * MW;
    localparam int SW   = SQW + 1;
    localparam int RW   = SQW + 2;
    localparam int TW   = lrgf_pkg::SLOPE_SQ_BITS;
    localparam int PW   = lrgf_pkg::PART_BITS;
    localparam int NP   = (SW + PW - 1) / PW;
    localparam int PPW  = PW + TW;
    localparam int RHW  = NP * PW + TW;
    localparam int LW   = SQW + lrgf_pkg::SLOPE_SHIFT;
    localparam int HW   = 3 * CB + 1;
    localparam int LAST = 6;

    function automatic logic [MW-1:0] mag(input logic [MW-1:0] d);
        mag = d[MW-1] ? (~d + 1'b1) : d;
    endfunction

    logic adv;
    logic in_fire;

    // held point
    logic [CB-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic          have_prev_reg;

    // stage valids and the held point with its start flag, carried down the pipe
    logic [LAST:0]  vld_reg;
    logic [HW-1:0]  hold_reg [0:LAST];

    // stage 0: new point
    logic [CB-1:0] nx_reg, ny_reg, nz_reg;

    // stage 1: differences and range components
    logic [MW-1:0] ax_reg, ay_reg, az_reg;
    logic [MW-1:0] rpx_reg, rpy_reg, rpz_reg, rnx_reg, rny_reg, rnz_reg;
    logic [MW-1:0] dx_next, dy_next, dz_next, dd_next, pzh_next, nzh_next;
    logic          dzpos_reg [1:5];
    logic          drop_reg  [1:5];

    // stage 2: squares
    logic [SQW-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [SQW-1:0] sqpx_reg, sqpy_reg, sqpz_reg, sqnx_reg, sqny_reg, sqnz_reg;

    // stage 3: sums
    logic [SW-1:0]  s_reg;
    logic [SQW-1:0] l_reg [3:5];
    logic [RW-1:0]  rp_reg, rn_reg;

    // stage 4: slope partial products and range test
    logic [NP*PW-1:0] s_pad;
    logic [PPW-1:0]   part_reg [0:NP-1];
    logic             range_reg [4:5];

    // stage 5: slope right-hand side
    logic [RHW-1:0] rhs_next, rhs_reg;

    // stage 6: break verdict
    logic [LW-1:0]  lhs;
    logic           brk_reg;

    // whole pipe moves unless the last stage is stuck on a full queue
    assign adv      = !(vld_reg[LAST] && q_full);
    assign in_ready = adv;
    assign in_fire  = in_valid && adv;
    assign q_push   = vld_reg[LAST] && !q_full;
    assign q_entry  = {brk_reg, hold_reg[LAST]};

    // held point and stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            vld_reg       <= '0;
        end else begin
            if (in_fire) begin
                have_prev_reg <= 1'b1;
                prev_x_reg    <= in_x;
                prev_y_reg    <= in_y;
                prev_z_reg    <= in_z;
            end
            if (adv) begin
                vld_reg <= {vld_reg[LAST-1:0], in_valid};
            end
        end
    end

    // stage 1 arithmetic
    always_comb begin
        dx_next  = MW'($signed(nx_reg)) - MW'($signed(hold_reg[0][CB-1:0]));
        dy_next  = MW'($signed(ny_reg)) - MW'($signed(hold_reg[0][2*CB-1:CB]));
        dz_next  = MW'($signed(nz_reg)) - MW'($signed(hold_reg[0][3*CB-1:2*CB]));
        dd_next  = MW'($signed(hold_reg[0][3*CB-1:2*CB])) - MW'($signed(nz_reg));
        pzh_next = MW'($signed(hold_reg[0][3*CB-1:2*CB])) - MW'(cfg.sensor_height);
        nzh_next = MW'($signed(nz_reg)) - MW'(cfg.sensor_height);
    end

    // slope partial products take fixed slices of the squared planar distance
    assign s_pad = (NP*PW)'(s_reg);

    // rhs of the slope test: sum of shifted partial products
    always_comb begin
        rhs_next = '0;
        for (int i = 0; i < NP; i++) begin
            rhs_next = rhs_next + (RHW'(part_reg[i]) << (i * PW));
        end
    end

    assign lhs = {l_reg[5], {lrgf_pkg::SLOPE_SHIFT{1'b0}}};

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 0
            nx_reg      <= in_x;
            ny_reg      <= in_y;
            nz_reg      <= in_z;
            hold_reg[0] <= {in_start || !have_prev_reg, prev_z_reg, prev_y_reg, prev_x_reg};
            for (int i = 1; i <= LAST; i++) begin
                hold_reg[i] <= hold_reg[i-1];
            end
            // stage 1
            ax_reg       <= mag(dx_next);
            ay_reg       <= mag(dy_next);
            az_reg       <= mag(dz_next);
            dzpos_reg[1] <= !dz_next[MW-1] && (dz_next != '0);
            drop_reg[1]  <= $signed(dd_next) > $signed(MW'(cfg.drop_limit));
            rpx_reg      <= mag(MW'($signed(hold_reg[0][CB-1:0])));
            rpy_reg      <= mag(MW'($signed(hold_reg[0][2*CB-1:CB])));
            rpz_reg      <= mag(pzh_next);
            rnx_reg      <= mag(MW'($signed(nx_reg)));
            rny_reg      <= mag(MW'($signed(ny_reg)));
            rnz_reg      <= mag(nzh_next);
            for (int i = 2; i <= 5; i++) begin
                dzpos_reg[i] <= dzpos_reg[i-1];
                drop_reg[i]  <= drop_reg[i-1];
            end
            // stage 2
            sqx_reg  <= ax_reg * ax_reg;
            sqy_reg  <= ay_reg * ay_reg;
            sqz_reg  <= az_reg * az_reg;
            sqpx_reg <= rpx_reg * rpx_reg;
            sqpy_reg <= rpy_reg * rpy_reg;
            sqpz_reg <= rpz_reg * rpz_reg;
            sqnx_reg <= rnx_reg * rnx_reg;
            sqny_reg <= rny_reg * rny_reg;
            sqnz_reg <= rnz_reg * rnz_reg;
            // stage 3
            s_reg    <= SW'(sqx_reg) + SW'(sqy_reg);
            l_reg[3] <= sqz_reg;
            rp_reg   <= RW'(sqpx_reg) + RW'(sqpy_reg) + RW'(sqpz_reg);
            rn_reg   <= RW'(sqnx_reg) + RW'(sqny_reg) + RW'(sqnz_reg);
            // stage 4
            for (int i = 0; i < NP; i++) begin
                part_reg[i] <= s_pad[i*PW +: PW] * cfg.slope_sq;
            end
            l_reg[4]     <= l_reg[3];
            range_reg[4] <= rp_reg > rn_reg;
            // stage 5
            rhs_reg      <= rhs_next;
            l_reg[5]     <= l_reg[4];
            range_reg[5] <= range_reg[4];
            // stage 6
            brk_reg <= (dzpos_reg[5] && (RHW'(lhs) > rhs_reg)) || drop_reg[5] || range_reg[5];
        end
    end

`ifndef SYNTHESIS
    // input is refused only when a finished verdict waits on the queue
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (vld_reg[LAST] && q_full))
        else $error("front stalled without a blocked verdict");

    // a point taken in always leaves a held point behind
    a_hold_after_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (have_prev_reg && vld_reg[0]))
        else $error("accepted point not held");
`endif

endmodule

### rtl/lrgf_queue.sv
// short queue between the break tests and the mode tracker
module lrgf_queue #(
    parameter int W = 74
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] rdata
);

    localparam int AW = lrgf_pkg::QUEUE_AW;
    localparam int DEPTH = lrgf_pkg::QUEUE_DEPTH;

    logic [W-1:0]  mem_reg [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full  = count_reg == (AW+1)'(DEPTH);
    assign valid = count_reg != '0;
    assign rdata = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full) && (count_reg <= (AW+1)'(DEPTH)))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("queue read while empty");
`endif

endmodule

### rtl/lrgf_back.sv
// back part: tracks seeking or after-break mode and drives the result register
module lrgf_back #(
    parameter int CB = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lrgf_pkg::lrgf_cfg_t cfg,
    input  logic                q_valid,
    input  logic [3*CB+1:0]     q_entry,   // x, y, z, start, break from lowest bit up
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CB-1:0]       m_x,
    output logic [CB-1:0]       m_y,
    output logic [CB-1:0]       m_z
);

    localparam int DW = CB + 1;

    logic [CB-1:0] e_x, e_y, e_z;
    logic          e_start, e_brk;
    logic [DW-1:0] rise_diff;
    logic          rise_ok;
    logic          emit;

    logic          after_break_reg, after_break_next;
    logic [CB-1:0] break_height_reg, break_height_next;
    logic          m_valid_reg;
    logic [CB-1:0] m_x_reg, m_y_reg, m_z_reg;

    assign e_x     = q_entry[CB-1:0];
    assign e_y     = q_entry[2*CB-1:CB];
    assign e_z     = q_entry[3*CB-1:2*CB];
    assign e_start = q_entry[3*CB];
    assign e_brk   = q_entry[3*CB+1];

    // take a verdict when the result register is free or being emptied
    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    // height above the break point against the rise limit
    assign rise_diff = DW'($signed(e_z)) - DW'($signed(break_height_reg));
    assign rise_ok   = $signed(rise_diff) <= $signed(DW'(cfg.rise_limit));
    assign emit      = !e_start && after_break_reg && !rise_ok;

    // mode update
    always_comb begin
        after_break_next  = after_break_reg;
        break_height_next = break_height_reg;
        if (e_start) begin
            after_break_next  = 1'b0;
            break_height_next = '0;
        end else if (!after_break_reg) begin
            if (e_brk) begin
                after_break_next  = 1'b1;
                break_height_next = e_z;
            end
        end else if (rise_ok) begin
            after_break_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_break_reg  <= 1'b0;
            break_height_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (q_pop) begin
                after_break_reg  <= after_break_next;
                break_height_reg <= break_height_next;
                m_valid_reg      <= emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (q_pop && emit) begin
            m_x_reg <= e_x;
            m_y_reg <= e_y;
            m_z_reg <= e_z;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_x     = m_x_reg;
    assign m_y     = m_y_reg;
    assign m_z     = m_z_reg;

`ifndef SYNTHESIS
    // a fresh result only comes out of after-break mode, which it leaves unchanged
    a_emit_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> after_break_reg)
        else $error("result emitted outside after-break mode");
`endif

endmodule

### tb/lidar_ray_ground_filter_test.sv
// self-checking testbench for the lidar ray ground filter with its own point classifier
`timescale 1ns / 1ps

module lidar_ray_ground_filter_test;

    localparam int COORD_W = 24;
    localparam int DATA_W  = ((3*COORD_W+7)/8)*8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASE_POINTS    = 98;

    // one point as it sits in tdata, x in the lowest bits
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    // where the expectation for a transfer comes from
    typedef enum logic [1:0] {
        FROM_MODEL,
        KNOWN_EMPTY,
        KNOWN_POINT
    } src_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      start;
        src_t                      src;
        logic signed [COORD_W-1:0] wx;
        logic signed [COORD_W-1:0] wy;
        logic signed [COORD_W-1:0] wz;
    } step_t;

    logic                                  aclk = 1'b0;
    logic                                  aresetn;
    logic                                  cfg_we;
    logic [lrgf_pkg::CFG_INDEX_BITS-1:0]   cfg_index;
    logic [lrgf_pkg::CFG_DATA_BITS-1:0]    cfg_wdata;
    logic                                  s_tvalid;
    logic                                  s_tready;
    logic [DATA_W-1:0]                     s_tdata;   // px, py, pz
    logic                                  s_tuser;   // ray_start
    logic                                  m_tvalid;
    logic                                  m_tready;
    logic [DATA_W-1:0]                     m_tdata;   // ox, oy, oz

    // tag travelling with the offered point
    src_t   cur_src;
    point_t cur_want;

    // classifier state and register copies
    logic [lrgf_pkg::SLOPE_BITS-1:0] slope_tan;
    logic [lrgf_pkg::LIMIT_BITS-1:0] drop_lim;
    logic [lrgf_pkg::LIMIT_BITS-1:0] rise_lim;
    logic [lrgf_pkg::LIMIT_BITS-1:0] sens_h;
    longint held_x, held_y, held_z, break_z;
    logic   have_held, in_break;

    point_t non_ground_q [$];
    int     errors       = 0;
    int     pts_sent     = 0;
    int     pts_taken    = 0;
    int     results_seen = 0;
    int     rays         = 0;
    int     settings     = 1;
    logic   calm         = 1'b0;
    logic   hold_go      = 1'b0;

    // directed points: typed verdicts where they are obvious, the rest predicted
    step_t plan [28] = '{
        '{0,     0, 0,     1'b0, KNOWN_EMPTY, 0, 0, 0},    // first point after reset opens a ray
        '{1000,  0, 0,     1'b0, KNOWN_EMPTY, 0, 0, 0},    // flat, moving away
        '{2000,  0, 2000,  1'b0, KNOWN_EMPTY, 0, 0, 0},    // steep rise breaks
        '{2100,  0, 2000,  1'b0, KNOWN_POINT, 2000, 0, 2000},
        '{2200,  0, 50,    1'b0, KNOWN_POINT, 2100, 0, 2000},
        '{2300,  0, 50,    1'b0, KNOWN_EMPTY, 0, 0, 0},    // back near the break, restart
        '{2400,  0, -200,  1'b0, KNOWN_EMPTY, 0, 0, 0},    // big drop breaks
        '{2500,  0, 300,   1'b0, KNOWN_EMPTY, 0, 0, 0},    // held is below break, restart
        '{2400,  0, 300,   1'b0, FROM_MODEL,  0, 0, 0},    // range shrinks
        '{0,     0, 0,     1'b1, KNOWN_EMPTY, 0, 0, 0},    // new ray drops held point
        '{100,   0, 1000,  1'b0, KNOWN_EMPTY, 0, 0, 0},
        '{200,   0, 1000,  1'b0, KNOWN_POINT, 100, 0, 1000},
        '{300,   0, 1000,  1'b1, KNOWN_EMPTY, 0, 0, 0},    // last point of ray never judged
        '{-8388608, -8388608, -8388608, 1'b1, KNOWN_EMPTY, 0, 0, 0},
        '{8388607,  8388607,  8388607,  1'b0, FROM_MODEL, 0, 0, 0},
        '{8388607,  8388607,  8388607,  1'b0, FROM_MODEL, 0, 0, 0},
        '{-1,    -1, -1,   1'b0, FROM_MODEL,  0, 0, 0},
        '{0,     0, 0,     1'b1, KNOWN_EMPTY, 0, 0, 0},
        '{0,     0, 5,     1'b0, FROM_MODEL,  0, 0, 0},    // vertical rise
        '{0,     0, 5,     1'b0, FROM_MODEL,  0, 0, 0},
        '{3000,  0, 0,     1'b1, KNOWN_EMPTY, 0, 0, 0},
        '{3100,  0, 100,   1'b0, FROM_MODEL,  0, 0, 0},    // exactly on the slope limit
        '{3200,  0, 201,   1'b0, FROM_MODEL,  0, 0, 0},    // just over it
        '{3300,  0, 201,   1'b0, KNOWN_POINT, 3200, 0, 201},
        '{3400,  0, 200,   1'b0, KNOWN_POINT, 3300, 0, 201},
        '{3500,  0, 200,   1'b0, KNOWN_EMPTY, 0, 0, 0},    // exactly on the rise limit
        '{3600,  0, 100,   1'b0, FROM_MODEL,  0, 0, 0},    // exactly on the drop limit
        '{3700,  0, -1,    1'b0, FROM_MODEL,  0, 0, 0}     // just over it
    };

    lidar_ray_ground_filter #(
        .COORD_BITS (COORD_W)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // squared magnitude, wide enough for every product below
    function automatic logic [127:0] sq(input longint d);
        logic [127:0] m;
        m = (d < 0) ? -d : d;
        return m * m;
    endfunction

    function automatic logic [127:0] range_sq(input longint x, input longint y,
                                              input longint z);
        longint h;
        h = sens_h;
        return sq(x) + sq(y) + sq(z - h);
    endfunction

    // slope, drop and range tests between the held point and the new one
    function automatic logic pair_breaks(input longint x, input longint y, input longint z);
        longint       dz, lim;
        logic [127:0] tan_sq;
        dz = z - held_z;
        tan_sq = slope_tan;
        tan_sq = tan_sq * tan_sq;
        lim = drop_lim;
        if (dz > 0 && (sq(dz) << lrgf_pkg::SLOPE_SHIFT) >
                      (sq(x - held_x) + sq(y - held_y)) * tan_sq)
            return 1'b1;
        if (held_z - z > lim)
            return 1'b1;
        return range_sq(held_x, held_y, held_z) > range_sq(x, y, z);
    endfunction

    // judge the held point on arrival of p; returns 1 with the point if non-ground
    function automatic logic judge_point(input point_t p, input logic start,
                                         output point_t res);
        longint nx, ny, nz, lim;
        logic   emit;
        nx = p.x;
        ny = p.y;
        nz = p.z;
        lim = rise_lim;
        emit = 1'b0;
        res = '0;
        if (start || !have_held) begin
            have_held = 1'b1;
            in_break  = 1'b0;
            break_z   = 0;
        end else if (!in_break) begin
            if (pair_breaks(nx, ny, nz)) begin
                in_break = 1'b1;
                break_z  = held_z;
            end
        end else if (held_z - break_z <= lim) begin
            in_break = 1'b0;
        end else begin
            res.x = held_x[COORD_W-1:0];
            res.y = held_y[COORD_W-1:0];
            res.z = held_z[COORD_W-1:0];
            emit = 1'b1;
        end
        held_x = nx;
        held_y = ny;
        held_z = nz;
        return emit;
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2*span)) - span;
    endfunction

    function automatic longint any_coord();
        logic signed [COORD_W-1:0] v;
        v = COORD_W'($urandom());
        return v;
    endfunction

    // predict on every input transfer, check every result transfer
    always @(posedge aclk) begin : scoreboard
        point_t res, got;
        if (aresetn && s_tvalid && s_tready) begin
            pts_taken++;
            if (judge_point(point_t'(s_tdata), s_tuser, res) && cur_src == FROM_MODEL)
                non_ground_q.insert(non_ground_q.size(), res);
            if (cur_src == KNOWN_POINT)
                non_ground_q.insert(non_ground_q.size(), cur_want);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (non_ground_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got (%0d, %0d, %0d)",
                         $time, got.x, got.y, got.z);
            end else begin
                res = non_ground_q.pop_front();
                if (got.x !== res.x || got.y !== res.y || got.z !== res.z) begin
                    errors++;
                    $display("%0t: result mismatch, expected (%0d, %0d, %0d), got (%0d, %0d, %0d)",
                             $time, res.x, res.y, res.z, got.x, got.y, got.z);
                end
            end
        end
    end

    // result side: random stalls, or a long hold-off on request
    initial begin : receiver
        int left;
        left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_go) begin
                hold_go = 1'b0;
                left = HOLD_OFF_CYCLES;
            end
            if (left > 0) begin
                left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // offer one point and wait for its transfer; called and returns at a falling edge
    task automatic send_point(input longint x, input longint y, input longint z,
                              input logic start, input src_t src, input point_t want);
        point_t p;
        p.x = x[COORD_W-1:0];
        p.y = y[COORD_W-1:0];
        p.z = z[COORD_W-1:0];
        while (!calm && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        s_tuser  <= start;
        cur_src  <= src;
        cur_want <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pts_sent++;
        @(negedge aclk);
    endtask

    // one ray: ground stretches, obstacles, wall tops, drops and backsteps
    task automatic send_ray(input int len);
        longint x, y, z, lim;
        int     sx, sy, r;
        x = jitter(500);
        y = jitter(500);
        z = jitter(200);
        if ($urandom_range(0, 4) == 0) begin
            x = jitter(4000000);
            y = jitter(4000000);
        end
        sx = $urandom_range(0, 1) ? 1 : -1;
        sy = $urandom_range(0, 1) ? 1 : -1;
        rays++;
        send_point(x, y, z, 1'b1, FROM_MODEL, '0);
        for (int i = 1; i < len; i++) begin
            r = $urandom_range(0, 99);
            lim = rise_lim;
            if (r < 55) begin
                x += sx * int'($urandom_range(50, 400));
                y += sy * int'($urandom_range(0, 300));
                z += jitter(20);
            end else if (r < 70) begin
                x += sx * int'($urandom_range(1, 20));
                z += ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, lim))
                                                 : lim + longint'($urandom_range(1, 2000));
            end else if (r < 82) begin
                x += sx * int'($urandom_range(20, 200));
                y += jitter(30);
                z += jitter(20);
            end else if (r < 92) begin
                x += sx * int'($urandom_range(1, 100));
                z -= longint'($urandom_range(0, 3000));
            end else begin
                x -= sx * int'($urandom_range(1, 300));
            end
            send_point(x, y, z, 1'b0, FROM_MODEL, '0);
        end
    endtask

    // a ray that climbs onto a long flat wall, every wall point non-ground
    task automatic send_wall(input int len);
        longint top;
        top = longint'(rise_lim) + 600;
        rays++;
        send_point(1000, 500, 0, 1'b1, FROM_MODEL, '0);
        for (int i = 0; i <= len; i++)
            send_point(1005 + 50*i, 500, top, 1'b0, FROM_MODEL, '0);
    endtask

    // write all four registers while the block is idle
    task automatic apply_settings(input logic [15:0] slope, input logic [15:0] drop,
                                  input logic [15:0] rise, input logic [15:0] height);
        logic [15:0] vals [4];
        vals = '{slope, drop, rise, height};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= (lrgf_pkg::CFG_INDEX_BITS)'(i);
            cfg_wdata <= vals[i];
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        slope_tan = slope[lrgf_pkg::SLOPE_BITS-1:0];
        drop_lim  = drop;
        rise_lim  = rise;
        sens_h    = height;
        settings++;
    endtask

    // let every expected result arrive, then let the pipeline empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (non_ground_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin : stimulus
        point_t want;
        int     mark;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = lrgf_pkg::CFG_SLOPE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cur_src   = FROM_MODEL;
        cur_want  = '0;
        slope_tan = (lrgf_pkg::SLOPE_BITS)'(256);
        drop_lim  = lrgf_pkg::DROP_RESET;
        rise_lim  = lrgf_pkg::RISE_RESET;
        sens_h    = lrgf_pkg::HEIGHT_RESET;
        held_x = 0;
        held_y = 0;
        held_z = 0;
        break_z = 0;
        have_held = 1'b0;
        in_break  = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table under reset register values
        for (int i = 0; i < $size(plan); i++) begin
            want.x = plan[i].wx;
            want.y = plan[i].wy;
            want.z = plan[i].wz;
            if (plan[i].start) rays++;
            send_point(plan[i].x, plan[i].y, plan[i].z, plan[i].start, plan[i].src, want);
        end
        drain();

        // random rays, stray points and a wall ray under several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: apply_settings(16'd4095, 16'd65535, 16'd65535, 16'd65535);
                1: apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
                2: apply_settings(16'd256, lrgf_pkg::DROP_RESET, lrgf_pkg::RISE_RESET,
                                  lrgf_pkg::HEIGHT_RESET);
                default: apply_settings(16'($urandom_range(0, 4095)),
                                        16'($urandom_range(0, 2000)),
                                        16'($urandom_range(0, 3000)),
                                        16'($urandom_range(0, 65535)));
            endcase
            mark = pts_sent;
            if (ph == 2) begin
                // no idling on either side, and one long receiver hold-off
                calm = 1'b1;
                hold_go = 1'b1;
                send_wall(40);
            end
            while (pts_sent - mark < PHASE_POINTS) begin
                if ($urandom_range(0, 9) == 0)
                    send_point(any_coord(), any_coord(), any_coord(),
                               1'($urandom_range(0, 1)), FROM_MODEL, '0);
                else
                    send_ray($urandom_range(3, 20));
            end
            calm = 1'b0;
            drain();
        end

        $display("run covered %0d points in %0d rays under %0d register settings",
                 pts_taken, rays, settings);
        $display("%0d non-ground results checked, %0d mismatches", results_seen, errors);
        if (errors == 0 && non_ground_q.size() == 0) begin
            $display("lidar_ray_ground_filter_test OK");
        end else begin
            $display("lidar_ray_ground_filter_test NOT OK");
        end
        $finish;
    end

    // overall time limit
    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d results outstanding", non_ground_q.size());
        $display("lidar_ray_ground_filter_test NOT OK");
        $finish;
    end

endmodule
